FILE: design/utp_pkg.sv
package utp_pkg;

   localparam int QueueDepth = 4;

   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpF   = 8'h46;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowF  = 8'h66;
   localparam logic [7:0] HexTen    = 8'd10;

   localparam logic [5:0] HyphenPos0 = 6'd8;
   localparam logic [5:0] HyphenPos1 = 6'd13;
   localparam logic [5:0] HyphenPos2 = 6'd18;
   localparam logic [5:0] HyphenPos3 = 6'd23;
   localparam logic [5:0] PlainLen   = 6'd32;
   localparam logic [5:0] DashedLen  = 6'd36;
   localparam logic [5:0] PosSat     = 6'd37;

   localparam logic [2:0] VariantRfc = 3'd2;

   // one classified character
   typedef struct packed {
      logic [3:0] nibble;
      logic       is_hex;
      logic       is_dash;
      logic       is_last;
   } item_type;

   typedef struct packed {
      logic        parse_ok;
      logic [31:0] time_low_out;
      logic [15:0] time_mid_out;
      logic [15:0] time_hi_version_out;
      logic [15:0] clock_seq_out;
      logic [47:0] node_out;
      logic [3:0]  version_nibble;
      logic [2:0]  variant_code;
   } result_type;

endpackage

FILE: design/uuid_text_parser.sv
// UUID text parser: takes a UUID string one ASCII character per transaction (tlast on the
// final character) and accepts either 32 hex digits or the 36-character form with '-' at
// offsets 8, 13, 18 and 23; hex digits may be either case. Each tlast character yields one
// response: tuser is 1 if the string was taken, and tdata carries the held UUID split into
// its fields plus version nibble and variant code. A rejected string leaves the held UUID
// (null after reset) unchanged. Characters classified on input enter a QUEUE_DEPTH-entry
// queue; the back end retires one character per cycle, so the block sustains one character
// per clock unless a tlast character waits in the queue, which it does only while the
// previous response is still unaccepted; responses come from an output register behind the queue.
module uuid_text_parser #(
   parameter int QUEUE_DEPTH = utp_pkg::QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] char_code
   input  logic         req_tlast,   // is_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] time_low_out, [47:32] time_mid_out, [63:48] time_hi_version_out,
   // [79:64] clock_seq_out, [127:80] node_out, [131:128] version_nibble,
   // [134:132] variant_code, [135] zero
   output logic [135:0] rsp_tdata,
   output logic         rsp_tuser    // parse_ok
);
   import utp_pkg::*;

   item_type   in_item;
   item_type   head_item;
   logic       q_not_full;
   logic       q_not_empty;
   logic       q_pop;
   result_type result;

   assign req_tready = q_not_full;

   utp_front u_front (
      .char_code (req_tdata),
      .is_last   (req_tlast),
      .item      (in_item)
   );

   utp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && q_not_full),
      .push_item (in_item),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .head_item (head_item),
      .not_empty (q_not_empty)
   );

   utp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (q_not_empty),
      .item         (head_item),
      .item_pop     (q_pop),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   assign rsp_tuser = result.parse_ok;
   assign rsp_tdata = {1'b0, result.variant_code, result.version_nibble, result.node_out,
                       result.clock_seq_out, result.time_hi_version_out,
                       result.time_mid_out, result.time_low_out};

endmodule

FILE: design/utp_front.sv
module utp_front (
   input  logic              [7:0] char_code,
   input  logic                    is_last,
   output utp_pkg::item_type       item
);
   import utp_pkg::*;

   always_comb begin
      item.is_last = is_last;
      item.is_dash = (char_code == CharDash);
      item.is_hex  = 1'b1;
      item.nibble  = 4'd0;
      if (char_code >= CharZero && char_code <= CharNine) begin
         item.nibble = 4'(char_code - CharZero);
      end else if (char_code >= CharUpA && char_code <= CharUpF) begin
         item.nibble = 4'(char_code - CharUpA + HexTen);
      end else if (char_code >= CharLowA && char_code <= CharLowF) begin
         item.nibble = 4'(char_code - CharLowA + HexTen);
      end else begin
         item.is_hex = 1'b0;
      end
   end

endmodule

FILE: design/utp_queue.sv
module utp_queue #(
   parameter int DEPTH = utp_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  utp_pkg::item_type push_item,
   output logic              not_full,
   input  logic              pop,
   output utp_pkg::item_type head_item,
   output logic              not_empty
);
   import utp_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   item_type        mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign not_full  = (count_ff != FullCnt);
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/utp_back.sv
module utp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  utp_pkg::item_type    item,
   output logic                 item_pop,
   output logic                 result_valid,
   input  logic                 result_ready,
   output utp_pkg::result_type  result
);
   import utp_pkg::*;

   logic [5:0]   pos_ff, pos_in;
   logic         hform_ff, hform_in;
   logic         dash_ff, dash_in;
   logic         bad_ff, bad_in;
   logic [127:0] acc_ff, acc_in;
   logic [127:0] held_ff, held_in;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_ff, rsp_in;

   logic       hform;
   logic       hyphen_pos;
   logic [5:0] len;
   logic       ok;
   logic [2:0] top3;

   // a character without tlast never needs the output register
   assign item_pop     = item_valid && (!item.is_last || !rsp_valid_ff || result_ready);
   assign result_valid = rsp_valid_ff;
   assign result       = rsp_ff;

   always_comb begin
      pos_in       = pos_ff;
      hform_in     = hform_ff;
      dash_in      = dash_ff;
      bad_in       = bad_ff;
      acc_in       = acc_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !result_ready;
      rsp_in       = rsp_ff;

      hform      = (pos_ff == '0) ? 1'b1 : hform_ff;
      hyphen_pos = (pos_ff == HyphenPos0) || (pos_ff == HyphenPos1) ||
                   (pos_ff == HyphenPos2) || (pos_ff == HyphenPos3);
      len        = pos_ff + 6'd1;
      ok         = 1'b0;
      top3       = 3'd0;

      if (item_pop) begin
         if (pos_ff < DashedLen) begin
            if (hyphen_pos) begin
               if (item.is_dash) begin
                  dash_in = 1'b1;
               end else begin
                  hform = 1'b0;
                  if (!item.is_hex) begin
                     bad_in = 1'b1;
                  end
               end
            end else if (!item.is_hex) begin
               bad_in = 1'b1;
            end
            if (item.is_hex) begin
               acc_in = {acc_ff[123:0], item.nibble};
            end
         end
         hform_in = hform;
         pos_in   = (pos_ff == PosSat) ? PosSat : len;

         if (item.is_last) begin
            ok = !bad_in && (((len == PlainLen) && !dash_in) ||
                             ((len == DashedLen) && hform));
            if (ok) begin
               held_in = acc_in;
            end
            top3 = held_in[63:61];
            rsp_valid_in               = 1'b1;
            rsp_in.parse_ok            = ok;
            rsp_in.time_low_out        = held_in[127:96];
            rsp_in.time_mid_out        = held_in[95:80];
            rsp_in.time_hi_version_out = held_in[79:64];
            rsp_in.clock_seq_out       = held_in[63:48];
            rsp_in.node_out            = held_in[47:0];
            rsp_in.version_nibble      = held_in[79:76];
            if (top3[2:1] == 2'b11) begin
               rsp_in.variant_code = top3;
            end else if (top3[2]) begin
               rsp_in.variant_code = VariantRfc;
            end else begin
               rsp_in.variant_code = 3'd0;
            end
            // start over for the next string
            pos_in   = '0;
            hform_in = 1'b0;
            dash_in  = 1'b0;
            bad_in   = 1'b0;
            acc_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hform_ff     <= 1'b0;
         dash_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         acc_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         hform_ff     <= hform_in;
         dash_ff      <= dash_in;
         bad_ff       <= bad_in;
         acc_ff       <= acc_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: tb/uuid_text_parser_tb.sv
module uuid_text_parser_tb;
   import utp_pkg::*;

   typedef logic [7:0] char_q_type[$];

   localparam int ClockPeriod  = 12;
   localparam int StallLimit   = 3000;
   localparam int DrainCycles  = 8;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         rsp_tuser;

   int send_idle_pct = 17;
   int recv_stall_pct = 63;
   int fail_count = 0;
   int quiet_cycles = 0;

   // string state of the predictor
   logic [5:0]   str_pos = '0;
   logic         str_hyphen_ok = 1'b0;
   logic         str_dash_seen = 1'b0;
   logic         str_bad = 1'b0;
   logic [127:0] str_nibbles = '0;
   logic [127:0] held_uuid = '0;

   result_type pending_parses[$];

   uuid_text_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Predict the effect of one accepted character; a tlast character queues one result.
   function automatic void parse_char(input logic [7:0] c, input logic last);
      logic [3:0] nib;
      logic       is_hex;
      logic       at_hyphen;
      logic       hform;
      logic       ok;
      logic [2:0] top;
      int         len;
      result_type r;
      is_hex = 1'b1;
      nib = '0;
      if (c >= CharZero && c <= CharNine) nib = 4'(c - CharZero);
      else if (c >= CharLowA && c <= CharLowF) nib = 4'(c - CharLowA + HexTen);
      else if (c >= CharUpA && c <= CharUpF) nib = 4'(c - CharUpA + HexTen);
      else is_hex = 1'b0;
      at_hyphen = (str_pos == HyphenPos0) || (str_pos == HyphenPos1) ||
                  (str_pos == HyphenPos2) || (str_pos == HyphenPos3);
      hform = (str_pos == 0) ? 1'b1 : str_hyphen_ok;
      if (str_pos < DashedLen) begin
         if (at_hyphen) begin
            if (c == CharDash) begin
               str_dash_seen = 1'b1;
            end else begin
               hform = 1'b0;
               if (!is_hex) str_bad = 1'b1;
            end
         end else if (!is_hex) begin
            str_bad = 1'b1;
         end
         if (is_hex) str_nibbles = {str_nibbles[123:0], nib};
      end
      str_hyphen_ok = hform;
      len = int'(str_pos) + 1;
      str_pos = (str_pos < PosSat) ? str_pos + 6'd1 : PosSat;
      if (!last) return;

      ok = !str_bad && ((len == PlainLen && !str_dash_seen) || (len == DashedLen && hform));
      if (ok) held_uuid = str_nibbles;
      r.parse_ok = ok;
      r.time_low_out = held_uuid[127:96];
      r.time_mid_out = held_uuid[95:80];
      r.time_hi_version_out = held_uuid[79:64];
      r.clock_seq_out = held_uuid[63:48];
      r.node_out = held_uuid[47:0];
      r.version_nibble = held_uuid[79:76];
      top = held_uuid[63:61];
      if (top[2:1] == 2'b11) r.variant_code = top;
      else if (top[2]) r.variant_code = VariantRfc;
      else r.variant_code = '0;
      pending_parses.push_back(r);

      str_pos = '0;
      str_hyphen_ok = 1'b0;
      str_dash_seen = 1'b0;
      str_bad = 1'b0;
      str_nibbles = '0;
   endfunction

   task automatic check_result();
      result_type want;
      if (pending_parses.size() == 0) begin
         report_mismatch("response with no string pending", 64'(rsp_tuser), 64'(0));
         return;
      end
      want = pending_parses.pop_front();
      if (rsp_tuser !== want.parse_ok)
         report_mismatch("parse_ok", 64'(rsp_tuser), 64'(want.parse_ok));
      if (rsp_tdata[31:0] !== want.time_low_out)
         report_mismatch("time_low", 64'(rsp_tdata[31:0]), 64'(want.time_low_out));
      if (rsp_tdata[47:32] !== want.time_mid_out)
         report_mismatch("time_mid", 64'(rsp_tdata[47:32]), 64'(want.time_mid_out));
      if (rsp_tdata[63:48] !== want.time_hi_version_out)
         report_mismatch("time_hi_version", 64'(rsp_tdata[63:48]),
                         64'(want.time_hi_version_out));
      if (rsp_tdata[79:64] !== want.clock_seq_out)
         report_mismatch("clock_seq", 64'(rsp_tdata[79:64]), 64'(want.clock_seq_out));
      if (rsp_tdata[127:80] !== want.node_out)
         report_mismatch("node", 64'(rsp_tdata[127:80]), 64'(want.node_out));
      if (rsp_tdata[131:128] !== want.version_nibble)
         report_mismatch("version", 64'(rsp_tdata[131:128]), 64'(want.version_nibble));
      if (rsp_tdata[134:132] !== want.variant_code)
         report_mismatch("variant", 64'(rsp_tdata[134:132]), 64'(want.variant_code));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
   end

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 10) return CharZero + 8'(v);
      return ($urandom_range(1) ? CharUpA : CharLowA) + 8'(v) - HexTen;
   endfunction

   function automatic char_q_type uuid_text(input logic [127:0] u, input bit dashed);
      char_q_type s;
      for (int i = 0; i < 32; i++) begin
         if (dashed && (i == 8 || i == 12 || i == 16 || i == 20)) s.push_back(CharDash);
         s.push_back(hex_char(u[127 - 4 * i -: 4]));
      end
      return s;
   endfunction

   function automatic logic [127:0] random_uuid();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic send_char(input logic [7:0] c, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_char(c, last);
   endtask

   task automatic send_string(input char_q_type s);
      foreach (s[i]) send_char(s[i], i == s.size() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_parses.size() != 0) @(posedge clock);
   endtask

   // wrong lengths first, so the null UUID is seen straight after reset
   task automatic test_short_strings();
      char_q_type s;
      s.push_back(CharZero);
      send_string(s);
      s = '{};
      s.push_back(8'hFF);
      send_string(s);
      s = uuid_text(random_uuid(), 1'b0);
      void'(s.pop_back());
      send_string(s);
      s = uuid_text(random_uuid(), 1'b0);
      s.push_back(hex_char(4'h7));
      send_string(s);
      s = uuid_text(random_uuid(), 1'b1);
      void'(s.pop_back());
      send_string(s);
   endtask

   task automatic test_plain_form();
      send_string(uuid_text('0, 1'b0));
      send_string(uuid_text('1, 1'b0));
      send_string(uuid_text(random_uuid(), 1'b0));
   endtask

   task automatic test_dashed_form();
      logic [127:0] u;
      u = random_uuid();
      u[79:76] = 4'h4;
      u[63:62] = 2'b10;
      send_string(uuid_text(u, 1'b1));
      u[63:61] = 3'b111;
      send_string(uuid_text(u, 1'b1));
      u[63:61] = 3'b110;
      send_string(uuid_text(u, 1'b1));
      send_string(uuid_text('1, 1'b1));
      // hold off until the parser has answered every string so far
      wait_drained();
      u[63:61] = 3'b011;
      send_string(uuid_text(u, 1'b1));
   endtask

   task automatic test_hyphen_errors();
      char_q_type s;
      s = uuid_text(random_uuid(), 1'b0);
      s[8] = CharDash;
      send_string(s);
      s = uuid_text(random_uuid(), 1'b0);
      s[5] = CharDash;
      send_string(s);
      s = uuid_text(random_uuid(), 1'b1);
      s[13] = hex_char(4'hA);
      send_string(s);
      s = uuid_text(random_uuid(), 1'b1);
      s[18] = 8'h67;   // 'g'
      send_string(s);
      s = uuid_text(random_uuid(), 1'b1);
      s[0] = 8'h80;
      send_string(s);
      s = uuid_text(random_uuid(), 1'b1);
      s[30] = CharDash;
      send_string(s);
   endtask

   // past 36 characters the position counter must saturate, not wrap
   task automatic test_long_strings();
      char_q_type s;
      s = uuid_text(random_uuid(), 1'b1);
      s.push_back(hex_char(4'h3));
      send_string(s);
      s = '{};
      repeat (70) s.push_back(8'($urandom_range(255)));
      send_string(s);
      s = uuid_text(random_uuid(), 1'b0);
      repeat (32) s.push_back(hex_char(4'(($urandom_range(15)))));
      send_string(s);
      send_string(uuid_text(random_uuid(), 1'b0));
   endtask

   task automatic test_random(input int n_chars);
      char_q_type s;
      int sent;
      int kind;
      int idx;
      int len;
      sent = 0;
      while (sent < n_chars) begin
         kind = $urandom_range(99);
         s = uuid_text(random_uuid(), kind < 35 || (kind >= 65 && kind < 72));
         if (kind >= 65 && kind < 80) begin
            idx = $urandom_range(s.size() - 1);
            case ($urandom_range(2))
               0: s[idx] = 8'($urandom_range(255));
               1: s[idx] = CharDash;
               default: s[idx] = hex_char(4'($urandom_range(15)));
            endcase
         end else if (kind >= 80 && kind < 90) begin
            idx = $urandom_range(s.size() - 1);
            if ($urandom_range(1)) s.delete(idx);
            else s.insert(idx, hex_char(4'($urandom_range(15))));
         end else if (kind >= 90) begin
            s = '{};
            len = $urandom_range(45, 1);
            repeat (len) begin
               if ($urandom_range(1)) s.push_back(8'($urandom_range(255)));
               else s.push_back(hex_char(4'($urandom_range(15))));
            end
         end
         send_string(s);
         sent += s.size();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_strings();
      test_plain_form();
      test_dashed_form();
      test_hyphen_errors();
      test_long_strings();

      test_random(200);
      send_idle_pct = 63;
      recv_stall_pct = 17;
      test_random(200);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random(200);

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_parses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
